FILE: rtl/core/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants
// Widths, register codes and divider constants of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 12;   // 9 * 255 fits
  localparam int CFG_W     = 13;   // widest register
  localparam int CFG_IDX_W = 1;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  // pixel counts of a window
  localparam int N_CORNER = 4;
  localparam int N_EDGE   = 6;
  localparam int N_INNER  = 9;

  // reciprocals of 2N scaled by 2^RECIP_SHIFT, rounded up
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_12    = 5462;
  localparam int RECIP_18    = 3641;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e_t;

  typedef enum logic [1:0] {
    NC_4 = 2'd0,
    NC_6 = 2'd1,
    NC_9 = 2'd2
  } ncode_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum3_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

endpackage
`default_nettype wire

FILE: rtl/core/bb3_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_if: pixel channels
// Valid/ready channels for input pixels and blurred result items.
// ----------------------------------------------------------------------------
interface pix_in_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::PIX_W-1:0] red_in;
  logic [bb3_pkg::PIX_W-1:0] green_in;
  logic [bb3_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface pix_out_if #(
  parameter int COL_W = 11,
  parameter int ROW_W = 12
);
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::PIX_W-1:0] red_out;
  logic [bb3_pkg::PIX_W-1:0] green_out;
  logic [bb3_pkg::PIX_W-1:0] blue_out;
  logic [ROW_W-1:0]          out_row;
  logic [COL_W-1:0]          out_col;
  logic                     last_of_run;
  logic                     frame_done;

  modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
                  last_of_run, frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col,
                  last_of_run, frame_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bb3_mean.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_mean: window mean
// Rounded-half-up mean (2*sum+N)/(2N) per channel, N of 4, 6 or 9,
// by shift or by reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_mean (
  input  bb3_pkg::sum3_t  sums,
  input  bb3_pkg::ncode_t ncode,
  output bb3_pkg::rgb_t   mean
);
  import bb3_pkg::*;

  function automatic logic [PIX_W-1:0] mean1(logic [SUM_W-1:0] s, ncode_t n);
    logic [SUM_W:0]     v;
    logic [2*SUM_W+1:0] p;
    logic [PIX_W-1:0]   q;
    v = '0;
    p = '0;
    q = '0;
    unique case (n)
      NC_4: begin
        v = {s, 1'b0} + (SUM_W+1)'(N_CORNER);
        q = v[PIX_W+2:3];
      end
      NC_6: begin
        v = {s, 1'b0} + (SUM_W+1)'(N_EDGE);
        p = (2*SUM_W+2)'(v) * (2*SUM_W+2)'(RECIP_12);
        q = p[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      end
      NC_9: begin
        v = {s, 1'b0} + (SUM_W+1)'(N_INNER);
        p = (2*SUM_W+2)'(v) * (2*SUM_W+2)'(RECIP_18);
        q = p[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      end
      default: q = '0;
    endcase
    return q;
  endfunction

  always_comb begin
    mean.r = mean1(sums.r, ncode);
    mean.g = mean1(sums.g, ncode);
    mean.b = mean1(sums.b, ncode);
  end

endmodule
`default_nettype wire

FILE: rtl/core/box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages: stage 1, stage 2, output register. Throughput: one pixel per cycle
// unless the output stalls; a pixel that yields k > 1 results (row end, last row)
// holds the input until all have left the window-sum stage, one result per cycle
// as stage 2 loads. The line stores are read once per pixel and written back once.
// Reset: counters, window and pipeline valids clear; width 640, height 480.
// Line store contents are undefined after reset and need no clearing.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: streaming 3x3 box blur
// Two line memories hold the two rows above, a 2-column window holds the
// neighborhood; each result is the rounded mean of its in-image neighbors.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  pix_in_if.sink                        pix_in,
  pix_out_if.source                     pix_out
);
  import bb3_pkg::*;

  localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_W'(RST_WIDTH);
      image_height <= IMG_H_W'(RST_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_idx == REG_IMAGE_WIDTH)  image_width  <= cfg_data[IMG_W_W-1:0];
      if (cfg_idx == REG_IMAGE_HEIGHT) image_height <= cfg_data[IMG_H_W-1:0];
    end
  end

  // saturated frame size
  logic [31:0] w_tmp, h_tmp;
  logic [CW:0] w_use, wm1_full;
  logic [RW:0] h_use, hm1_full;

  always_comb begin
    if (32'(image_width) < 32'd2)                w_tmp = 32'd2;
    else if (32'(image_width) > 32'(MAX_WIDTH))  w_tmp = 32'(MAX_WIDTH);
    else                                         w_tmp = 32'(image_width);
    if (32'(image_height) < 32'd2)               h_tmp = 32'd2;
    else if (32'(image_height) > 32'(MAX_HEIGHT)) h_tmp = 32'(MAX_HEIGHT);
    else                                         h_tmp = 32'(image_height);
    w_use    = w_tmp[CW:0];
    h_use    = h_tmp[RW:0];
    wm1_full = w_use - 1'b1;
    hm1_full = h_use - 1'b1;
  end

  // handshake and pipeline control
  logic in_acc, s1_done, s2_load, s3_load, emit;
  logic s1_v, s2_v, out_v;

  assign in_acc       = pix_in.valid & pix_in.ready;
  assign pix_in.ready = ~s1_v | s1_done;
  assign s3_load      = ~out_v | pix_out.ready;
  assign s2_load      = ~s2_v | s3_load;

  // raster position of the arriving pixel
  logic [CW-1:0] col_count, col_count_next, x_cur;
  logic [RW-1:0] row_count, row_count_next, y_cur;
  logic [RW:0]   row_tmp;
  logic          x_last, y_last;

  always_comb begin
    if ({1'b0, col_count} >= w_use) begin
      x_cur   = '0;
      row_tmp = {1'b0, row_count} + 1'b1;
    end else begin
      x_cur   = col_count;
      row_tmp = {1'b0, row_count};
    end
    y_cur  = (row_tmp >= h_use) ? '0 : row_tmp[RW-1:0];
    x_last = ({1'b0, x_cur} == wm1_full);
    y_last = ({1'b0, y_cur} == hm1_full);
    if (x_last) begin
      col_count_next = '0;
      row_count_next = y_last ? '0 : y_cur + 1'b1;
    end else begin
      col_count_next = x_cur + 1'b1;
      row_count_next = y_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line memories: read on accept, written back when the pixel retires
  logic [3*PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [3*PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [3*PIX_W-1:0] older_rd, newer_rd, cur_pix;
  logic [3*PIX_W-1:0] s1_cur;
  logic [CW-1:0]      s1_x;

  assign cur_pix = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  always_ff @(posedge clk) begin
    if (in_acc) older_rd <= older_mem[x_cur];
    if (s1_done) older_mem[s1_x] <= newer_rd;
  end

  always_ff @(posedge clk) begin
    if (in_acc) newer_rd <= newer_mem[x_cur];
    if (s1_done) newer_mem[s1_x] <= s1_cur;
  end

  // stage 1: pixel in flight and its pending result slots
  // slot 0/1: row above, at x-1 / at the right edge; slot 2/3: same for last row
  logic [RW-1:0] s1_y;
  logic [CW-1:0] s1_wm1;
  logic          s1_xge2, s1_yge2;
  logic [3:0]    s1_mask, new_mask, pick, rem_after;

  always_comb begin
    new_mask[0] = (y_cur != '0) & (x_cur != '0);
    new_mask[1] = (y_cur != '0) & x_last;
    new_mask[2] = y_last & (x_cur != '0);
    new_mask[3] = y_last & x_last;
  end

  assign pick      = s1_mask & (~s1_mask + 4'd1);
  assign rem_after = s1_mask & ~pick;
  assign emit      = s1_v & (s1_mask != '0);
  assign s1_done   = s1_v & ((s1_mask == '0) | (s2_load & (rem_after == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_acc) begin
      s1_v <= 1'b1;
    end else if (s1_done) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mask <= new_mask;
      s1_x    <= x_cur;
      s1_y    <= y_cur;
      s1_wm1  <= wm1_full[CW-1:0];
      s1_xge2 <= (32'(x_cur) >= 32'd2);
      s1_yge2 <= (32'(y_cur) >= 32'd2);
      s1_cur  <= cur_pix;
    end else if (emit & s2_load) begin
      s1_mask <= rem_after;
    end
  end

  // window: two columns of three rows, shifted when a pixel retires
  logic [3*PIX_W-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (s1_done) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= older_rd;
      win[4] <= newer_rd;
      win[5] <= s1_cur;
    end
  end

  // window sum for the selected slot
  logic               is_edge, is_lastrow;
  logic [3*PIX_W-1:0] pc [3][3];
  logic [2:0]         col_ok, row_ok;
  sum3_t              sum_cur;
  ncode_t             ncode_cur;
  logic [RW-1:0]      row_cur;
  logic [CW-1:0]      col_cur;

  always_comb begin
    is_edge    = pick[1] | pick[3];
    is_lastrow = pick[2] | pick[3];
    if (is_edge) begin
      pc[0][0] = win[3];   pc[0][1] = win[4];   pc[0][2] = win[5];
      pc[1][0] = older_rd; pc[1][1] = newer_rd; pc[1][2] = s1_cur;
      pc[2][0] = older_rd; pc[2][1] = newer_rd; pc[2][2] = s1_cur;
      col_ok   = 3'b011;
    end else begin
      pc[0][0] = win[0];   pc[0][1] = win[1];   pc[0][2] = win[2];
      pc[1][0] = win[3];   pc[1][1] = win[4];   pc[1][2] = win[5];
      pc[2][0] = older_rd; pc[2][1] = newer_rd; pc[2][2] = s1_cur;
      col_ok   = {1'b1, 1'b1, s1_xge2};
    end
    row_ok  = is_lastrow ? 3'b110 : {1'b1, 1'b1, s1_yge2};
    sum_cur = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[c] & row_ok[r]) begin
          sum_cur.r = sum_cur.r + SUM_W'(pc[c][r][3*PIX_W-1:2*PIX_W]);
          sum_cur.g = sum_cur.g + SUM_W'(pc[c][r][2*PIX_W-1:PIX_W]);
          sum_cur.b = sum_cur.b + SUM_W'(pc[c][r][PIX_W-1:0]);
        end
      end
    end
    // three columns and three rows: 9; two of each: 4; otherwise 6
    if ((&col_ok) & (&row_ok))          ncode_cur = NC_9;
    else if (~(&col_ok) & ~(&row_ok))   ncode_cur = NC_4;
    else                                ncode_cur = NC_6;
    row_cur = is_lastrow ? s1_y : s1_y - 1'b1;
    col_cur = is_edge ? s1_wm1 : s1_x - 1'b1;
  end

  // stage 2: sums of one result
  sum3_t         s2_sum;
  ncode_t        s2_n;
  logic [RW-1:0] s2_row;
  logic [CW-1:0] s2_col;
  logic          s2_last, s2_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_load) begin
      s2_v <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load & emit) begin
      s2_sum  <= sum_cur;
      s2_n    <= ncode_cur;
      s2_row  <= row_cur;
      s2_col  <= col_cur;
      s2_last <= (rem_after == '0);
      s2_done <= pick[3];
    end
  end

  // mean per channel
  rgb_t mean;

  bb3_mean u_mean (
    .sums  (s2_sum),
    .ncode (s2_n),
    .mean  (mean)
  );

  // output register
  rgb_t          o_rgb;
  logic [RW-1:0] o_row;
  logic [CW-1:0] o_col;
  logic          o_last, o_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s3_load) begin
      out_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load & s2_v) begin
      o_rgb  <= mean;
      o_row  <= s2_row;
      o_col  <= s2_col;
      o_last <= s2_last;
      o_done <= s2_done;
    end
  end

  assign pix_out.valid       = out_v;
  assign pix_out.red_out     = o_rgb.r;
  assign pix_out.green_out   = o_rgb.g;
  assign pix_out.blue_out    = o_rgb.b;
  assign pix_out.out_row     = o_row;
  assign pix_out.out_col     = o_col;
  assign pix_out.last_of_run = o_last;
  assign pix_out.frame_done  = o_done;

  // checks
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_v & o_done |-> o_last)
    else $error("frame end result not marked last of run");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> ({1'b0, s1_x} <= {1'b0, s1_wm1}))
    else $error("pixel column beyond frame width");

  a_corner_sum: assert property (@(posedge clk) disable iff (rst)
    s2_v & (s2_n == NC_4) |-> (s2_sum.r <= SUM_W'(4 * 255)))
    else $error("corner window sum out of range");

  a_retire_once: assert property (@(posedge clk) disable iff (rst)
    s1_done & ~in_acc |=> ~s1_v)
    else $error("pixel retired but still held");

endmodule
`default_nettype wire

FILE: tb/tb_box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware: self-checking bench for the 3x3 box blur
// Streams RGB frames through the blur and checks each result item against a
// behavioral copy of the blur: line stores, window, counters, rounded means.
// Directed frames, some with hand-computed outputs, come first. Random
// frames follow under several idle and stall patterns, then one mid-frame
// width change and the saturated extremes of both size registers.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware;
  import bb3_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_CYC  = 6;

  typedef struct {
    logic [7:0]  r, g, b;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
    logic        done;
  } blur_res_t;

  // directed row: pixel, and where known the result count and channel value
  typedef struct {
    logic [7:0] r, g, b;
    bit         known;
    int         cnt;
    logic [7:0] val;
  } dir_row_t;

  // random phase: register values, pixel count, idle mode
  typedef struct {
    int w_reg, h_reg, npix, mode;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  pix_in_if  pix_in();
  pix_out_if pix_out();

  box_blur_3x3_edge_aware dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // blur state mirror
  logic [23:0] older_line [DEF_MAX_WIDTH];
  logic [23:0] newer_line [DEF_MAX_WIDTH];
  logic [23:0] win_cols [6];
  int          row_cnt, col_cnt;
  int          img_w_reg, img_h_reg;

  blur_res_t blurred_q[$];
  int        errors      = 0;
  int        pix_sent    = 0;
  int        res_seen    = 0;
  int        snd_pct     = 0;
  int        rcv_pct     = 0;
  int        quiet_cyc   = 0;
  int        frames_done = 0;

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // rounded mean of the in-image pixels of one window
  function automatic blur_res_t window_mean(input logic [23:0] cols [3][3],
                                            input bit cok [3], input bit rok [3],
                                            input int orow, input int ocol,
                                            input bit done);
    int        sr, sg, sb, n;
    blur_res_t res;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        if (cok[c] && rok[r]) begin
          sr += cols[c][r][23:16];
          sg += cols[c][r][15:8];
          sb += cols[c][r][7:0];
          n++;
        end
    if (n == 0) n = 1;
    res.r    = 8'((2 * sr + n) / (2 * n));
    res.g    = 8'((2 * sg + n) / (2 * n));
    res.b    = 8'((2 * sb + n) / (2 * n));
    res.row  = 12'(orow);
    res.col  = 11'(ocol);
    res.last = 1'b0;
    res.done = done;
    return res;
  endfunction

  // advance the mirror by one pixel and queue the blurred items it releases
  task automatic blur_pixel(input rgb_t px, output int nres);
    int          w, h, x, y, orow, start;
    logic [23:0] cc [3];
    logic [23:0] inner [3][3];
    logic [23:0] right [3][3];
    bit          in_ok [3], rt_ok [3], rok [3];
    w = clamp(img_w_reg, 2, DEF_MAX_WIDTH);
    h = clamp(img_h_reg, 2, DEF_MAX_HEIGHT);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    cc[0] = older_line[x];
    cc[1] = newer_line[x];
    cc[2] = px;
    older_line[x] = cc[1];
    newer_line[x] = cc[2];
    for (int r = 0; r < 3; r++) begin
      inner[0][r] = win_cols[r];
      inner[1][r] = win_cols[3 + r];
      inner[2][r] = cc[r];
      right[0][r] = win_cols[3 + r];
      right[1][r] = cc[r];
      right[2][r] = cc[r];
    end
    in_ok = '{x >= 2, 1'b1, 1'b1};
    rt_ok = '{1'b1, 1'b1, 1'b0};
    start = blurred_q.size();
    for (int p = 0; p < 2; p++) begin
      if (p == 0 && y < 1) continue;
      if (p == 1 && y != h - 1) continue;
      orow = (p == 0) ? y - 1 : y;
      rok  = '{p == 0 && y >= 2, 1'b1, 1'b1};
      if (x >= 1) blurred_q.push_back(window_mean(inner, in_ok, rok, orow, x - 1, 1'b0));
      if (x == w - 1) blurred_q.push_back(window_mean(right, rt_ok, rok, orow, w - 1, p == 1));
    end
    for (int r = 0; r < 3; r++) begin
      win_cols[r]     = win_cols[3 + r];
      win_cols[3 + r] = cc[r];
    end
    if (x == w - 1) begin
      col_cnt = 0;
      row_cnt = (y == h - 1) ? 0 : y + 1;
      if (y == h - 1) frames_done++;
    end else begin
      col_cnt = x + 1;
    end
    nres = blurred_q.size() - start;
    if (nres > 0) blurred_q[blurred_q.size() - 1].last = 1'b1;
  endtask

  // drive one pixel, honoring sender idle, and wait for it to be taken
  task automatic send_pixel(input rgb_t px, output int nres);
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= px.r;
    pix_in.green_in <= px.g;
    pix_in.blue_in  <= px.b;
    do @(posedge clk); while (!pix_in.ready);
    blur_pixel(px, nres);
    pix_sent++;
  endtask

  // wait until all queued items are out and the pipeline is empty
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e_t idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) img_w_reg = val & 12'hFFF;
    else img_h_reg = val & 13'h1FFF;
  endtask

  task automatic set_mode(input int mode);
    snd_pct = (mode == 1) ? 60 : (mode == 3) ? 21 : 0;
    rcv_pct = (mode == 2) ? 60 : (mode == 3) ? 21 : 0;
  endtask

  // channel value leaning on the extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px.r = rand_chan();
    px.g = rand_chan();
    px.b = rand_chan();
    return px;
  endfunction

  // receiver: random stall and check of each taken item
  always @(posedge clk) begin
    blur_res_t e;
    pix_out.ready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);
    if (!rst && pix_out.valid && pix_out.ready) begin
      res_seen++;
      if (blurred_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected item row %0d col %0d", pix_out.out_row, pix_out.out_col);
      end else begin
        e = blurred_q.pop_front();
        if (pix_out.red_out !== e.r || pix_out.green_out !== e.g ||
            pix_out.blue_out !== e.b || pix_out.out_row !== e.row ||
            pix_out.out_col !== e.col || pix_out.last_of_run !== e.last ||
            pix_out.frame_done !== e.done) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $write("mismatch exp rgb %0d/%0d/%0d rc %0d,%0d l%0b d%0b",
                   e.r, e.g, e.b, e.row, e.col, e.last, e.done);
            $display(" got %0d/%0d/%0d rc %0d,%0d l%0b d%0b",
                     pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                     pix_out.out_row, pix_out.out_col, pix_out.last_of_run,
                     pix_out.frame_done);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // directed frames: 2x2 white, 2x2 black, 2x2 rounding, then a 3x3 pattern
  dir_row_t dir_tab [21] = '{
    '{8'hFF, 8'hFF, 8'hFF, 1, 0, 8'hFF}, '{8'hFF, 8'hFF, 8'hFF, 1, 0, 8'hFF},
    '{8'hFF, 8'hFF, 8'hFF, 1, 0, 8'hFF}, '{8'hFF, 8'hFF, 8'hFF, 1, 4, 8'hFF},
    '{8'h00, 8'h00, 8'h00, 1, 0, 8'h00}, '{8'h00, 8'h00, 8'h00, 1, 0, 8'h00},
    '{8'h00, 8'h00, 8'h00, 1, 0, 8'h00}, '{8'h00, 8'h00, 8'h00, 1, 4, 8'h00},
    '{8'd2,  8'd1,  8'hFF, 0, 0, 8'h00}, '{8'h00, 8'h00, 8'h00, 0, 0, 8'h00},
    '{8'h00, 8'h00, 8'h00, 0, 0, 8'h00}, '{8'h00, 8'h00, 8'h01, 0, 0, 8'h00},
    '{8'hFF, 8'h00, 8'hAA, 0, 0, 8'h00}, '{8'h00, 8'hFF, 8'h55, 0, 0, 8'h00},
    '{8'hFF, 8'h00, 8'hAA, 0, 0, 8'h00}, '{8'h00, 8'hFF, 8'h55, 0, 0, 8'h00},
    '{8'hFF, 8'h00, 8'hAA, 0, 0, 8'h00}, '{8'h00, 8'hFF, 8'h55, 0, 0, 8'h00},
    '{8'hFF, 8'h00, 8'hAA, 0, 0, 8'h00}, '{8'h00, 8'hFF, 8'h55, 0, 0, 8'h00},
    '{8'h80, 8'h7F, 8'h01, 0, 0, 8'h00}
  };

  // one full frame each, then partial frames at the saturated sizes
  phase_t phases [8] = '{
    '{5, 4, 20, 0}, '{8, 3, 24, 1}, '{4, 5, 20, 2}, '{1, 6, 12, 3},
    '{6, 2, 12, 3}, '{3, 3, 9, 1}, '{4095, 0, 8, 0}, '{0, 8191, 30, 2}
  };

  initial begin
    rgb_t px;
    int   nres, base;
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    row_cnt   = 0;
    col_cnt   = 0;
    img_w_reg = RST_WIDTH;
    img_h_reg = RST_HEIGHT;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    set_mode(0);
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    for (int i = 0; i < 21; i++) begin
      if (i == 12) begin
        drain();
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
      end
      px = '{dir_tab[i].r, dir_tab[i].g, dir_tab[i].b};
      send_pixel(px, nres);
      if (dir_tab[i].known) begin
        if (nres != dir_tab[i].cnt) begin
          errors++;
          $display("row %0d of directed table: %0d items predicted, %0d typed",
                   i, nres, dir_tab[i].cnt);
        end
        base = blurred_q.size() - nres;
        for (int k = base; k < blurred_q.size(); k++) begin
          blurred_q[k].r = dir_tab[i].val;
          blurred_q[k].g = dir_tab[i].val;
          blurred_q[k].b = dir_tab[i].val;
        end
      end
    end
    drain();

    // random frames, first six phases small
    for (int p = 0; p < 6; p++) begin
      set_mode(phases[p].mode);
      write_reg(REG_IMAGE_WIDTH, phases[p].w_reg);
      write_reg(REG_IMAGE_HEIGHT, phases[p].h_reg);
      for (int i = 0; i < phases[p].npix; i++) send_pixel(rand_pixel(), nres);
      drain();
    end

    // width cut mid-frame: row ends early and the next row is the last
    set_mode(3);
    write_reg(REG_IMAGE_WIDTH, 8);
    write_reg(REG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 21; i++) send_pixel(rand_pixel(), nres);
    drain();
    write_reg(REG_IMAGE_WIDTH, 3);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(), nres);
    drain();

    // saturated extremes: start of a widest row, then rows of the tallest
    // narrow frame, entered mid-frame so the wide row ends early
    for (int p = 6; p < 8; p++) begin
      set_mode(phases[p].mode);
      write_reg(REG_IMAGE_WIDTH, phases[p].w_reg);
      write_reg(REG_IMAGE_HEIGHT, phases[p].h_reg);
      for (int i = 0; i < phases[p].npix; i++) send_pixel(rand_pixel(), nres);
      drain();
    end

    $display("Blurred %0d pixels into %0d items over %0d frames,", pix_sent, res_seen,
             frames_done);
    $display("sizes 2x2 to 8x3, idle and stall, a mid-frame cut, saturated sizes.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_if.sv
rtl/core/bb3_mean.sv
rtl/core/box_blur_3x3_edge_aware.sv
tb/tb_box_blur_3x3_edge_aware.sv
